[src/hic_pkg.sv]
// Package for the hexagonal ijk coordinate unit.
// Holds the action codes, field widths and the constants of the divide-by-seven path.
// No dependencies; every other file of the block refers to it by scoped names.
package hic_pkg;

	// Widths of the channel fields.
	localparam int unsigned ACTION_W = 4;
	localparam int unsigned COORD_W  = 31;
	localparam int unsigned RES_W    = 34;
	localparam int unsigned DIGIT_W  = 3;

	// Width of the signed internal datapath. All intermediate values of every
	// action stay within +/- 2^33, so 35 bits hold them without wrap.
	localparam int unsigned WIDE_W = 35;

	typedef logic signed [WIDE_W-1:0] wide_t;

	// Action codes. Codes beyond ACT_ROT_CW behave as ACT_NORMALIZE.
	typedef enum logic [ACTION_W-1:0] {
		ACT_NORMALIZE = 4'd0,
		ACT_TO_DIGIT  = 4'd1,
		ACT_UP7       = 4'd2,
		ACT_UP7R      = 4'd3,
		ACT_DOWN7     = 4'd4,
		ACT_DOWN7R    = 4'd5,
		ACT_NEIGHBOR  = 4'd6,
		ACT_ROT_CCW   = 4'd7,
		ACT_ROT_CW    = 4'd8
	} action_t;

	// Digit returned when a triple is not one of the seven unit vectors.
	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 3'd7;

	// Rounding bias: round(n/7) with ties away from zero is floor((|n|+3)/7).
	localparam wide_t RND_BIAS = 35'sd3;

	// Divide by seven. The biased magnitude u (below 2^34) is split as
	// u = hi*2^18 + lo. Since 2^18 = 7*37449 + 1, floor(u/7) equals
	// hi*37449 + floor((hi+lo)/7). The second part, with hi+lo below 2^19,
	// is a multiply by ceil(2^22/7) followed by a right shift of 22.
	localparam int unsigned MAG_W      = 34;
	localparam int unsigned SPLIT      = 18;
	localparam int unsigned HI_W       = MAG_W - SPLIT;
	localparam int unsigned SUM_W      = SPLIT + 1;
	localparam int unsigned HI_PROD_W  = 32;
	localparam int unsigned RECIP_W    = 20;
	localparam int unsigned RECIP_SH   = 22;
	localparam int unsigned LO_PROD_W  = SUM_W + RECIP_W;
	localparam int unsigned LO_Q_W     = LO_PROD_W - RECIP_SH;
	localparam int unsigned QUOT_W     = 33;

	localparam logic [HI_PROD_W-1:0] HI_WEIGHT = 32'd37449;
	localparam logic [RECIP_W-1:0]   RECIP7    = 20'd599187;

endpackage

[src/hic_channels.sv]
// Channel interfaces of the hexagonal ijk coordinate unit.
// hic_cmd_if carries command transactions, hic_rsp_if carries result transactions.
// Depends on hic_pkg for the field widths.
interface hic_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [hic_pkg::ACTION_W-1:0]        action;
	logic signed [hic_pkg::COORD_W-1:0]  coord_i;
	logic signed [hic_pkg::COORD_W-1:0]  coord_j;
	logic signed [hic_pkg::COORD_W-1:0]  coord_k;
	logic [hic_pkg::DIGIT_W-1:0]         dir_digit;

	modport source (
		output valid, action, coord_i, coord_j, coord_k, dir_digit,
		input  ready
	);
	modport sink (
		input  valid, action, coord_i, coord_j, coord_k, dir_digit,
		output ready
	);
endinterface

interface hic_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [hic_pkg::RES_W-1:0]    res_i;
	logic [hic_pkg::RES_W-1:0]    res_j;
	logic [hic_pkg::RES_W-1:0]    res_k;
	logic [hic_pkg::DIGIT_W-1:0]  res_digit;

	modport source (
		output valid, res_i, res_j, res_k, res_digit,
		input  ready
	);
	modport sink (
		input  valid, res_i, res_j, res_k, res_digit,
		output ready
	);
endinterface

[src/hex_ijk_coordinate_unit.sv]
// Top level of the hexagonal ijk coordinate unit: a stateless pipelined datapath.
// Depends on hic_pkg and on the channel interfaces in hic_channels.sv.
// Contains the whole pipeline and its checks.
//
// Usage:
// A command transaction on cmd carries an action code, a signed (i,j,k) triple
// and a direction digit. Each command produces exactly one result transaction
// on rsp with the normalized triple (smallest component zero, all nonnegative)
// and, for the to_digit action, the matching direction digit.
//
// Throughput is one transaction per cycle while rsp is not stalled. The block
// takes a new command in every cycle in which the output register is empty or
// is being emptied, so it keeps accepting while a finished result waits only
// as long as a slot frees at the output in the same cycle.
// From the accepting edge to rsp.valid a command passes through the input
// register, the numerator stage, the magnitude stage, the multiply stage of
// the divide by seven, the sign and select stage, and the normalize stage
// that loads the output register. The multiply stage sets the clock figure.
// When the receiver stalls, the whole pipeline holds and cmd.ready drops.
// Reset clears every stage's valid bit; no transaction is in flight after it.
module hex_ijk_coordinate_unit (
	input  logic              clk,
	input  logic              arst_n,
	hic_cmd_if.sink           cmd,
	hic_rsp_if.source         rsp
);

	// Pipeline advance: every stage moves forward together whenever the
	// output register can take a new value.
	logic adv;
	logic out_valid_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign cmd.ready = adv;

	// Valid bits of the stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register.
	// ------------------------------------------------------------------
	logic [hic_pkg::ACTION_W-1:0]       act_s1;
	logic signed [hic_pkg::COORD_W-1:0] ci_s1, cj_s1, ck_s1;
	logic [hic_pkg::DIGIT_W-1:0]        dig_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= cmd.action;
			ci_s1  <= cmd.coord_i;
			cj_s1  <= cmd.coord_j;
			ck_s1  <= cmd.coord_k;
			dig_s1 <= cmd.dir_digit;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 logic: numerators of the parent step and the direct vector of
	// every other action.
	// ------------------------------------------------------------------
	hic_pkg::wide_t wi, wj, wk, da, db;
	hic_pkg::wide_t n0_c, n1_c, d0_c, d1_c, d2_c;
	logic           step_ok;

	always_comb begin
		wi = hic_pkg::wide_t'(ci_s1);
		wj = hic_pkg::wide_t'(cj_s1);
		wk = hic_pkg::wide_t'(ck_s1);
		da = wi - wk;
		db = wj - wk;
		// A valid neighbor digit maps onto the unit vector whose components
		// are the digit's bits, i from the top bit down to k from the bottom.
		step_ok = (dig_s1 != hic_pkg::DIGIT_NONE);

		if (act_s1 == hic_pkg::ACT_UP7R) begin
			n0_c = (da <<< 1) + db;
			n1_c = (db <<< 1) + db - da;
		end else begin
			n0_c = (da <<< 1) + da - db;
			n1_c = da + (db <<< 1);
		end

		case (act_s1)
			hic_pkg::ACT_DOWN7: begin
				d0_c = (wi <<< 1) + wi + wj;
				d1_c = (wj <<< 1) + wj + wk;
				d2_c = wi + (wk <<< 1) + wk;
			end
			hic_pkg::ACT_DOWN7R: begin
				d0_c = (wi <<< 1) + wi + wk;
				d1_c = wi + (wj <<< 1) + wj;
				d2_c = wj + (wk <<< 1) + wk;
			end
			hic_pkg::ACT_NEIGHBOR: begin
				d0_c = wi + hic_pkg::wide_t'({1'b0, dig_s1[2] & step_ok});
				d1_c = wj + hic_pkg::wide_t'({1'b0, dig_s1[1] & step_ok});
				d2_c = wk + hic_pkg::wide_t'({1'b0, dig_s1[0] & step_ok});
			end
			hic_pkg::ACT_ROT_CCW: begin
				d0_c = wi + wk;
				d1_c = wi + wj;
				d2_c = wj + wk;
			end
			hic_pkg::ACT_ROT_CW: begin
				d0_c = wi + wj;
				d1_c = wj + wk;
				d2_c = wi + wk;
			end
			default: begin
				d0_c = wi;
				d1_c = wj;
				d2_c = wk;
			end
		endcase
	end

	logic [hic_pkg::ACTION_W-1:0] act_s2;
	hic_pkg::wide_t               n0_s2, n1_s2, d0_s2, d1_s2, d2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= act_s1;
			n0_s2  <= n0_c;
			n1_s2  <= n1_c;
			d0_s2  <= d0_c;
			d1_s2  <= d1_c;
			d2_s2  <= d2_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 logic: biased magnitudes |n|+3 for the rounded division.
	// ------------------------------------------------------------------
	hic_pkg::wide_t u0_c, u1_c;

	always_comb begin
		u0_c = n0_s2[hic_pkg::WIDE_W-1] ? (hic_pkg::RND_BIAS - n0_s2)
		                                : (n0_s2 + hic_pkg::RND_BIAS);
		u1_c = n1_s2[hic_pkg::WIDE_W-1] ? (hic_pkg::RND_BIAS - n1_s2)
		                                : (n1_s2 + hic_pkg::RND_BIAS);
	end

	logic [hic_pkg::ACTION_W-1:0] act_s3;
	logic                         neg0_s3, neg1_s3;
	logic [hic_pkg::MAG_W-1:0]    u0_s3, u1_s3;
	hic_pkg::wide_t               d0_s3, d1_s3, d2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3  <= act_s2;
			neg0_s3 <= n0_s2[hic_pkg::WIDE_W-1];
			neg1_s3 <= n1_s2[hic_pkg::WIDE_W-1];
			u0_s3   <= u0_c[hic_pkg::MAG_W-1:0];
			u1_s3   <= u1_c[hic_pkg::MAG_W-1:0];
			d0_s3   <= d0_s2;
			d1_s3   <= d1_s2;
			d2_s3   <= d2_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 logic: divide by seven, as the weighted upper part plus the
	// reciprocal multiply of the folded sum.
	// ------------------------------------------------------------------
	logic [hic_pkg::SUM_W-1:0]     t0_c, t1_c;
	logic [hic_pkg::HI_PROD_W-1:0] ph0_c, ph1_c;
	logic [hic_pkg::LO_PROD_W-1:0] pl0_c, pl1_c;

	always_comb begin
		t0_c  = hic_pkg::SUM_W'(u0_s3[hic_pkg::MAG_W-1:hic_pkg::SPLIT])
		      + hic_pkg::SUM_W'(u0_s3[hic_pkg::SPLIT-1:0]);
		t1_c  = hic_pkg::SUM_W'(u1_s3[hic_pkg::MAG_W-1:hic_pkg::SPLIT])
		      + hic_pkg::SUM_W'(u1_s3[hic_pkg::SPLIT-1:0]);
		ph0_c = hic_pkg::HI_PROD_W'(u0_s3[hic_pkg::MAG_W-1:hic_pkg::SPLIT])
		      * hic_pkg::HI_WEIGHT;
		ph1_c = hic_pkg::HI_PROD_W'(u1_s3[hic_pkg::MAG_W-1:hic_pkg::SPLIT])
		      * hic_pkg::HI_WEIGHT;
		pl0_c = hic_pkg::LO_PROD_W'(t0_c) * hic_pkg::LO_PROD_W'(hic_pkg::RECIP7);
		pl1_c = hic_pkg::LO_PROD_W'(t1_c) * hic_pkg::LO_PROD_W'(hic_pkg::RECIP7);
	end

	logic [hic_pkg::ACTION_W-1:0]  act_s4;
	logic                          neg0_s4, neg1_s4;
	logic [hic_pkg::HI_PROD_W-1:0] ph0_s4, ph1_s4;
	logic [hic_pkg::LO_Q_W-1:0]    ql0_s4, ql1_s4;
	hic_pkg::wide_t                d0_s4, d1_s4, d2_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4  <= act_s3;
			neg0_s4 <= neg0_s3;
			neg1_s4 <= neg1_s3;
			ph0_s4  <= ph0_c;
			ph1_s4  <= ph1_c;
			ql0_s4  <= pl0_c[hic_pkg::LO_PROD_W-1:hic_pkg::RECIP_SH];
			ql1_s4  <= pl1_c[hic_pkg::LO_PROD_W-1:hic_pkg::RECIP_SH];
			d0_s4   <= d0_s3;
			d1_s4   <= d1_s3;
			d2_s4   <= d2_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5 logic: quotient, restored sign, and the pre-normalize vector.
	// ------------------------------------------------------------------
	logic [hic_pkg::QUOT_W-1:0] q0_c, q1_c;
	hic_pkg::wide_t             r0_c, r1_c, v0_c, v1_c, v2_c;
	logic                       is_up;

	always_comb begin
		q0_c  = hic_pkg::QUOT_W'(ph0_s4) + hic_pkg::QUOT_W'(ql0_s4);
		q1_c  = hic_pkg::QUOT_W'(ph1_s4) + hic_pkg::QUOT_W'(ql1_s4);
		r0_c  = neg0_s4 ? -hic_pkg::wide_t'(q0_c) : hic_pkg::wide_t'(q0_c);
		r1_c  = neg1_s4 ? -hic_pkg::wide_t'(q1_c) : hic_pkg::wide_t'(q1_c);
		is_up = (act_s4 == hic_pkg::ACT_UP7) || (act_s4 == hic_pkg::ACT_UP7R);
		if (is_up) begin
			v0_c = r0_c;
			v1_c = r1_c;
			v2_c = '0;
		end else begin
			v0_c = d0_s4;
			v1_c = d1_s4;
			v2_c = d2_s4;
		end
	end

	logic           to_digit_s5;
	hic_pkg::wide_t v0_s5, v1_s5, v2_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			to_digit_s5 <= (act_s4 == hic_pkg::ACT_TO_DIGIT);
			v0_s5       <= v0_c;
			v1_s5       <= v1_c;
			v2_s5       <= v2_c;
		end
	end

	// ------------------------------------------------------------------
	// Output stage logic: remove the common minimum. The result then has a
	// zero component and the rest nonnegative. The digit of a unit vector is
	// its three components read as bits, i first.
	// ------------------------------------------------------------------
	hic_pkg::wide_t              m01, mn, e0, e1, e2;
	logic                        unit_like;
	logic [hic_pkg::DIGIT_W-1:0] digit_c;

	always_comb begin
		m01 = (v1_s5 < v0_s5) ? v1_s5 : v0_s5;
		mn  = (v2_s5 < m01) ? v2_s5 : m01;
		e0  = v0_s5 - mn;
		e1  = v1_s5 - mn;
		e2  = v2_s5 - mn;
		unit_like = (e0[hic_pkg::RES_W-1:1] == '0) && (e1[hic_pkg::RES_W-1:1] == '0)
		         && (e2[hic_pkg::RES_W-1:1] == '0);
		if (!to_digit_s5) begin
			digit_c = '0;
		end else if (unit_like) begin
			digit_c = {e0[0], e1[0], e2[0]};
		end else begin
			digit_c = hic_pkg::DIGIT_NONE;
		end
	end

	logic [hic_pkg::RES_W-1:0]   res_i_q, res_j_q, res_k_q;
	logic [hic_pkg::DIGIT_W-1:0] res_digit_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_i_q     <= e0[hic_pkg::RES_W-1:0];
			res_j_q     <= e1[hic_pkg::RES_W-1:0];
			res_k_q     <= e2[hic_pkg::RES_W-1:0];
			res_digit_q <= digit_c;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.res_i     = res_i_q;
	assign rsp.res_j     = res_j_q;
	assign rsp.res_k     = res_k_q;
	assign rsp.res_digit = res_digit_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------

	// A delivered triple is normalized: at least one component is zero.
	a_norm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.res_i == '0) || (rsp.res_j == '0) || (rsp.res_k == '0))
		else $error("result triple has no zero component");

	// A real direction digit only comes with a unit vector triple.
	a_digit_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.res_digit != '0) && (rsp.res_digit != hic_pkg::DIGIT_NONE))
		|-> (rsp.res_i < 2) && (rsp.res_j < 2) && (rsp.res_k < 2))
		else $error("direction digit given for a triple that is not a unit vector");

	// A stalled output register freezes the whole pipeline, so no stage may
	// change its valid bit while the receiver holds ready low.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("pipeline moved while the output was stalled");

endmodule
